### hw/rtl/video_unit_register_and_timing_unit_macros.svh
// Assertion macros shared by the register and timing unit.
// Depends on a clock named clock and a synchronous reset named reset in the using module.
`ifndef VIDEO_UNIT_REGISTER_AND_TIMING_UNIT_MACROS_SVH
`define VIDEO_UNIT_REGISTER_AND_TIMING_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define VRT_ASSERT_IMPLIES(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vrt assertion failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define VRT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vrt assertion failed: next-cycle implication");

`endif

### hw/rtl/vrt_pkg.sv
// Package of the register and timing unit: constants, codes and beat types.
// No dependencies; imported by every module of the unit.
package vrt_pkg;

   localparam int unsigned VIDEO_DEPTH  = 16384;
   localparam int unsigned VADDR_W      = $clog2(VIDEO_DEPTH);
   localparam int unsigned SPRITE_DEPTH = 256;
   localparam int unsigned SADDR_W      = $clog2(SPRITE_DEPTH);

   localparam int unsigned RSPQ_DEPTH = 3;
   localparam int unsigned RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int unsigned RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);
   localparam int unsigned OCC_W      = RSPQ_CNT_W + 1;

   localparam logic [15:0] TOP_ADDRESS = 16'h3F1F;
   localparam logic [15:0] STEP_WIDE   = 16'd32;
   localparam logic [15:0] STEP_NARROW = 16'd1;

   localparam logic [8:0] LAST_LINE   = 9'd261;
   localparam logic [8:0] VBLANK_LINE = 9'd241;

   localparam logic [7:0] STATUS_CLR_VBLANK = 8'h7F;
   localparam logic [7:0] STATUS_CLR_HIT    = 8'hBF;
   localparam logic [7:0] STATUS_SET_VBLANK = 8'h80;

   localparam int unsigned CTRL_NMI_BIT      = 7;
   localparam int unsigned CTRL_STEP_BIT     = 2;
   localparam int unsigned STATUS_VBLANK_BIT = 7;

   // Operation codes
   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Register indexes
   localparam logic [2:0] REG_CTRL_ONE    = 3'd0;
   localparam logic [2:0] REG_CTRL_TWO    = 3'd1;
   localparam logic [2:0] REG_STATUS      = 3'd2;
   localparam logic [2:0] REG_SPRITE_ADDR = 3'd3;
   localparam logic [2:0] REG_SPRITE_DATA = 3'd4;
   localparam logic [2:0] REG_SCROLL      = 3'd5;
   localparam logic [2:0] REG_VIDEO_ADDR  = 3'd6;
   localparam logic [2:0] REG_VIDEO_DATA  = 3'd7;

   typedef struct packed {
      logic [1:0] operation;
      logic [2:0] register_index;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       nmi_pulse;
      logic       address_error;
   } rsp_type;

   typedef struct packed {
      logic               vmem_we;
      logic               vmem_re;
      logic [VADDR_W-1:0] vaddr;
      logic [7:0]         wdata;
      logic               smem_we;
      logic [SADDR_W-1:0] saddr;
   } mem_cmd_type;

   typedef struct packed {
      logic    sel_mem;
      rsp_type rsp;
   } ctrl_res_type;

endpackage

### hw/rtl/vrt_ctrl.sv
// Register file and line timing of the unit; issues memory commands for accepted beats that access memory.
// Depends on vrt_pkg and the unit's assertion macros.
`include "video_unit_register_and_timing_unit_macros.svh"

module vrt_ctrl
   import vrt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_type      req,
   output mem_cmd_type  mem_cmd,
   output ctrl_res_type res
);

   logic [7:0]  ctrl_one_ff, ctrl_one_in;
   logic [7:0]  ctrl_two_ff, ctrl_two_in;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  sprite_addr_ff, sprite_addr_in;
   logic [15:0] video_address_ff, video_address_in;
   logic        toggle_ff, toggle_in;
   logic [8:0]  line_ff, line_in;

   always_comb begin
      ctrl_one_in      = ctrl_one_ff;
      ctrl_two_in      = ctrl_two_ff;
      status_in        = status_ff;
      sprite_addr_in   = sprite_addr_ff;
      video_address_in = video_address_ff;
      toggle_in        = toggle_ff;
      line_in          = line_ff;
      mem_cmd          = '0;
      mem_cmd.vaddr    = video_address_ff[VADDR_W-1:0];
      mem_cmd.wdata    = req.write_data;
      mem_cmd.saddr    = sprite_addr_ff[SADDR_W-1:0];
      res              = '0;
      if (accept) begin
         unique case (req.operation)
            OP_READ: begin
               if (req.register_index == REG_STATUS) begin
                  res.rsp.read_data = status_ff;
                  status_in         = status_ff & STATUS_CLR_VBLANK;
               end else if (req.register_index == REG_VIDEO_DATA) begin
                  mem_cmd.vmem_re = 1'b1;
                  res.sel_mem     = 1'b1;
               end
            end
            OP_WRITE: begin
               unique case (req.register_index)
                  REG_CTRL_ONE:    ctrl_one_in    = req.write_data;
                  REG_CTRL_TWO:    ctrl_two_in    = req.write_data;
                  REG_SPRITE_ADDR: sprite_addr_in = req.write_data;
                  REG_SPRITE_DATA: mem_cmd.smem_we = 1'b1;
                  REG_VIDEO_ADDR: begin
                     if (!toggle_ff) begin
                        video_address_in = {req.write_data, 8'h00};
                     end else begin
                        video_address_in = video_address_ff | {8'h00, req.write_data};
                     end
                     toggle_in = ~toggle_ff;
                  end
                  REG_VIDEO_DATA: begin
                     if (video_address_ff > TOP_ADDRESS) begin
                        // drop the write and flag it; the address holds
                        res.rsp.address_error = 1'b1;
                     end else begin
                        mem_cmd.vmem_we  = 1'b1;
                        video_address_in = video_address_ff +
                           (ctrl_one_ff[CTRL_STEP_BIT] ? STEP_WIDE : STEP_NARROW);
                     end
                  end
                  default: ;  // status and scroll writes change nothing
               endcase
            end
            OP_TICK: begin
               if (line_ff == LAST_LINE) begin
                  status_in = status_ff & STATUS_CLR_VBLANK;
                  line_in   = '0;
               end else begin
                  if (line_ff == VBLANK_LINE) begin
                     res.rsp.nmi_pulse = ctrl_one_ff[CTRL_NMI_BIT];
                     status_in = (status_ff | STATUS_SET_VBLANK) & STATUS_CLR_HIT;
                  end
                  line_in = line_ff + 9'd1;
               end
            end
            default: ;  // unused operation code
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_one_ff      <= '0;
         ctrl_two_ff      <= '0;
         status_ff        <= '0;
         sprite_addr_ff   <= '0;
         video_address_ff <= '0;
         toggle_ff        <= 1'b0;
         line_ff          <= LAST_LINE;
      end else begin
         ctrl_one_ff      <= ctrl_one_in;
         ctrl_two_ff      <= ctrl_two_in;
         status_ff        <= status_in;
         sprite_addr_ff   <= sprite_addr_in;
         video_address_ff <= video_address_in;
         toggle_ff        <= toggle_in;
         line_ff          <= line_in;
      end
   end

   `VRT_ASSERT_IMPLIES(a_vmem_write_in_range, mem_cmd.vmem_we, video_address_ff <= TOP_ADDRESS)
   `VRT_ASSERT_IMPLIES(a_vmem_one_access, 1'b1, !(mem_cmd.vmem_we && mem_cmd.vmem_re))
   `VRT_ASSERT_IMPLIES(a_vblank_rise, $rose(status_ff[STATUS_VBLANK_BIT]), $past(line_ff) == VBLANK_LINE)
   `VRT_ASSERT_IMPLIES(a_nmi_on_tick, res.rsp.nmi_pulse, accept && line_ff == VBLANK_LINE)

endmodule

### hw/rtl/vrt_mem.sv
// Video and sprite memories of the unit; video memory read data is registered.
// Depends on vrt_pkg.
module vrt_mem
   import vrt_pkg::*;
(
   input  logic        clock,
   input  mem_cmd_type mem_cmd,
   output logic [7:0]  rd_data
);

   logic [7:0] vmem [VIDEO_DEPTH];
   logic [7:0] smem [SPRITE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.vmem_we) begin
         vmem[mem_cmd.vaddr] <= mem_cmd.wdata;
      end
      if (mem_cmd.vmem_re) begin
         rd_data_ff <= vmem[mem_cmd.vaddr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_cmd.smem_we) begin
         smem[mem_cmd.saddr] <= mem_cmd.wdata;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/vrt_rsp_q.sv
// Small result queue that parts the pipeline from the result channel.
// Depends on vrt_pkg.
module vrt_rsp_q
   import vrt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rsp_type               push_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   output logic [RSPQ_CNT_W-1:0] count
);

   rsp_type                 entry_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_CNT_W-1:0]   count_ff, count_in;
   logic                    pop;

   localparam logic [RSPQ_PTR_W-1:0] LAST_PTR = RSPQ_PTR_W'(RSPQ_DEPTH - 1);

   assign pop = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

### hw/rtl/video_unit_register_and_timing_unit.sv
// Register face and line timing of the video unit. An accepted beat passes the memory
// read stage and then the queue stage before its result shows on rsp_valid. Throughput:
// one beat per cycle while req_stall is low.
// Reset: req_stall held high; control, status, sprite and video address, toggle cleared,
// line set to 261; memories are not cleared and read as undefined until written. Depends on
// vrt_pkg, vrt_ctrl, vrt_mem, vrt_rsp_q and the unit's assertion macros.
`include "video_unit_register_and_timing_unit_macros.svh"

module video_unit_register_and_timing_unit
   import vrt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                  accept;
   mem_cmd_type           mem_cmd;
   ctrl_res_type          ctrl_res;
   logic [7:0]            mem_rd_data;

   // Read stage: holds the beat while the video memory read completes.
   logic                  p1_valid_ff;
   ctrl_res_type          p1_res_ff;
   rsp_type               p1_rsp;

   logic [RSPQ_CNT_W-1:0] q_count;
   logic [OCC_W-1:0]      occupancy;

   // Count beats in flight past the input: read stage plus queued results.
   // Stall during reset and once the queue could not take everything already
   // in flight; this depends only on registers and reset, so the result side
   // never reaches req_stall.
   assign occupancy = OCC_W'(p1_valid_ff) + OCC_W'(q_count);
   assign req_stall = reset || (occupancy >= OCC_W'(RSPQ_DEPTH));
   assign accept    = req_valid && !req_stall;

   // Registers update at accept; memory write and read issue on the same edge.
   // A read is always issued at a later edge than any earlier write, so no
   // forwarding is needed on the video memory.
   vrt_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .mem_cmd (mem_cmd),
      .res     (ctrl_res)
   );

   vrt_mem u_mem (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_res_ff <= ctrl_res;
      end
   end

   // Merge memory data into the beat when it was a data-port read.
   always_comb begin
      p1_rsp = p1_res_ff.rsp;
      if (p1_res_ff.sel_mem) begin
         p1_rsp.read_data = mem_rd_data;
      end
   end

   vrt_rsp_q u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (p1_valid_ff),
      .push_data (p1_rsp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .count     (q_count)
   );

   `VRT_ASSERT_IMPLIES(a_occupancy_bound, 1'b1, occupancy <= OCC_W'(RSPQ_DEPTH))
   `VRT_ASSERT_NEXT(a_push_lands, p1_valid_ff, rsp_valid)
   `VRT_ASSERT_NEXT(a_mem_read_tracks, accept && ctrl_res.sel_mem, p1_valid_ff && p1_res_ff.sel_mem)

endmodule
